@@ design/spq_pkg.sv @@
// ============================================================================
// spq_pkg: shared types for the stable priority queue
// Holds the result status codes, the datapath operation codes and the
// command and status groups that pass between the controller and datapath.
// ============================================================================
package spq_pkg;

    // Field widths fixed by the interface
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned OCC_W   = 5;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Request type codes
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    // Operation that the datapath carries out in its execute cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_REJECT_EMPTY,
        OP_REJECT_FULL
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        op_t  op;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_remove;
        logic empty;
        logic full;
    } dp_status_t;

endpackage

@@ design/spq_ctrl.sv @@
// ============================================================================
// spq_ctrl: request sequencer for the stable priority queue
// Accepts one item at a time, runs it through the execute state and keeps
// the output valid flag until the result item is taken.
// ============================================================================
module spq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  spq_pkg::dp_status_t dp_status,
    output spq_pkg::cmd_t       cmd
);
    import spq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // A new item may enter in the idle state once the result slot is free or is being emptied.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state, output flag and datapath command
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.capture    = 1'b0;
        cmd.op         = OP_NONE;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (dp_status.req_remove)
                begin
                    cmd.op = dp_status.empty ? OP_REJECT_EMPTY : OP_REMOVE;
                end
                else
                begin
                    cmd.op = dp_status.full ? OP_REJECT_FULL : OP_INSERT;
                end
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/spq_datapath.sv @@
// ============================================================================
// spq_datapath: sorted cell chain of the stable priority queue
// Each cell compares its own priority with the new item, so an insert or a
// remove updates the whole chain in parallel. Cell 0 is the front.
// ============================================================================
module spq_datapath
#(
    parameter int unsigned QUEUE_DEPTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  spq_pkg::cmd_t                        cmd,
    output spq_pkg::dp_status_t                  dp_status,
    input  logic                                 req_type,
    input  logic signed [spq_pkg::VALUE_W-1:0]   item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]    item_priority,
    output logic signed [spq_pkg::VALUE_W-1:0]   out_value,
    output logic        [1:0]                    status,
    output logic        [spq_pkg::OCC_W-1:0]     occupancy
);
    import spq_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Latched request
    logic                      req_remove_reg;
    logic signed [VALUE_W-1:0] req_value_reg;
    logic signed [PRIO_W-1:0]  req_prio_reg;

    // Cell chain and fill count
    logic signed [PRIO_W-1:0]  prio_reg   [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0]  prio_next  [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] value_reg  [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] value_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    stay;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    // Result registers
    logic signed [VALUE_W-1:0] out_value_reg;
    logic signed [VALUE_W-1:0] out_value_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;

    assign dp_status.req_remove = req_remove_reg;
    assign dp_status.empty      = (count_reg == '0);
    assign dp_status.full       = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Capture the request at acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_remove_reg <= (req_type == REQ_REMOVE);
            req_value_reg  <= item_value;
            req_prio_reg   <= item_priority;
        end
    end

    // One cell per slot: an occupied cell whose priority is equal or higher
    // keeps its entry; the first cell past them takes the new item and the
    // rest take their front neighbor. A remove moves every entry forward.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign stay[i] = (count_reg > CNT_W'(i)) && (prio_reg[i] >= req_prio_reg);

        always_comb
        begin
            prio_next[i]  = prio_reg[i];
            value_next[i] = value_reg[i];
            if (cmd.op == OP_INSERT)
            begin
                if (!stay[i])
                begin
                    if (i == 0)
                    begin
                        prio_next[i]  = req_prio_reg;
                        value_next[i] = req_value_reg;
                    end
                    else if (stay[(i == 0) ? 0 : i - 1])
                    begin
                        prio_next[i]  = req_prio_reg;
                        value_next[i] = req_value_reg;
                    end
                    else
                    begin
                        prio_next[i]  = prio_reg[(i == 0) ? 0 : i - 1];
                        value_next[i] = value_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
            else if (cmd.op == OP_REMOVE)
            begin
                if (i < QUEUE_DEPTH - 1)
                begin
                    prio_next[i]  = prio_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                    value_next[i] = value_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            prio_reg[i]  <= prio_next[i];
            value_reg[i] <= value_next[i];
        end
    end

    // Result and fill count for the executed operation
    always_comb
    begin
        count_next     = count_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        unique case (cmd.op)
            OP_INSERT:
            begin
                count_next     = count_reg + CNT_W'(1);
                out_value_next = '0;
                status_next    = ST_OK;
            end
            OP_REMOVE:
            begin
                count_next     = count_reg - CNT_W'(1);
                out_value_next = value_reg[0];
                status_next    = ST_OK;
            end
            OP_REJECT_EMPTY:
            begin
                out_value_next = '0;
                status_next    = ST_EMPTY;
            end
            OP_REJECT_FULL:
            begin
                out_value_next = '0;
                status_next    = ST_FULL;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Occupancy is the new count taken modulo the field width
    if (CNT_W >= OCC_W)
    begin : g_occ_trunc
        assign occ_next = (cmd.op == OP_NONE) ? occ_reg : count_next[OCC_W-1:0];
    end
    else
    begin : g_occ_ext
        assign occ_next = (cmd.op == OP_NONE) ? occ_reg
                                              : {{(OCC_W - CNT_W){1'b0}}, count_next};
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        occ_reg       <= occ_next;
    end

    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule

@@ design/stable_priority_queue_unit.sv @@
// ============================================================================
// stable_priority_queue_unit: bounded sorted priority queue
// Inserts keep entries in descending priority with equal priorities in
// arrival order; removes return the front entry. One result per request.
// ============================================================================
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------
//  input   | req_type, item_value, item_priority       | in_valid/in_ready
//  output  | out_value, status, occupancy              | out_valid/out_ready
//
// An item is accepted in the idle state; in the execute state the whole cell
// chain compares and shifts in parallel, after which its result is registered.
// A new item is accepted while the previous result still waits, as long as
// that result is taken in the same cycle or the slot is already free.
// A stalled output holds one result and blocks only the next request.
// Reset empties the queue at once; the cell contents need no clearing.
//
module stable_priority_queue_unit
#(
    parameter int unsigned QUEUE_DEPTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic signed [spq_pkg::VALUE_W-1:0] item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]  item_priority,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [spq_pkg::VALUE_W-1:0] out_value,
    output logic        [1:0]                  status,
    output logic        [spq_pkg::OCC_W-1:0]   occupancy
);
    import spq_pkg::*;

    cmd_t       cmd;
    dp_status_t dp_status;

    // Sequencer
    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Cell chain and result registers
    spq_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .req_type      (req_type),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_value     (out_value),
        .status        (status),
        .occupancy     (occupancy)
    );

endmodule

@@ design/spq_checker.sv @@
// ============================================================================
// spq_checker: port-level checks for the stable priority queue
// Watches the handshakes and result fields of the top level over time.
// ============================================================================
module spq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic [1:0]  status,
    input logic [4:0]  occupancy
);
    import spq_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
            && $stable(status) && $stable(occupancy))
        else $error("result changed while stalled");

    // Each accepted item drops in_ready while it executes and then yields a result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 out_valid)
        else $error("result did not follow accepted item");

    // A remove from an empty queue reports no data and zero occupancy.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> out_value == '0 && occupancy == '0)
        else $error("empty remove result malformed");

    // A rejected insert on a full queue reports no data.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> out_value == '0)
        else $error("full insert result carries data");

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .status    (status),
    .occupancy (occupancy)
);
